@@ rtl/core/ont_pkg.sv @@
package ont_pkg;

    localparam int STRING_BUFFER_DEF  = 1024;
    localparam int WORD_BUFFER_DEF    = 64;
    localparam int STRING_LIMIT_RESET = 1023;
    localparam int WORD_LIMIT_RESET   = 63;

    localparam int CFG_INDEX_W    = 1;
    localparam int CFG_DATA_W     = 10;
    localparam int WORD_LIMIT_W   = 6;
    localparam int LINE_W         = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_STRING_LIMIT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WORD_LIMIT   = 1'b1;

    localparam int MODE_W = 4;
    localparam logic [MODE_W-1:0] M_IDLE     = 4'd0;
    localparam logic [MODE_W-1:0] M_SLASH    = 4'd1;
    localparam logic [MODE_W-1:0] M_COMMENT  = 4'd2;
    localparam logic [MODE_W-1:0] M_STR      = 4'd3;
    localparam logic [MODE_W-1:0] M_STR_ESC  = 4'd4;
    localparam logic [MODE_W-1:0] M_STR_DROP = 4'd5;
    localparam logic [MODE_W-1:0] M_ZERO     = 4'd6;
    localparam logic [MODE_W-1:0] M_DEC      = 4'd7;
    localparam logic [MODE_W-1:0] M_HEX      = 4'd8;
    localparam logic [MODE_W-1:0] M_IDENT    = 4'd9;

    localparam logic [3:0] K_LBRACE   = 4'd0;
    localparam logic [3:0] K_RBRACE   = 4'd1;
    localparam logic [3:0] K_LBRACKET = 4'd2;
    localparam logic [3:0] K_RBRACKET = 4'd3;
    localparam logic [3:0] K_COLON    = 4'd4;
    localparam logic [3:0] K_COMMA    = 4'd5;
    localparam logic [3:0] K_STRING   = 4'd6;
    localparam logic [3:0] K_NUMBER   = 4'd7;
    localparam logic [3:0] K_TRUE     = 4'd8;
    localparam logic [3:0] K_FALSE    = 4'd9;
    localparam logic [3:0] K_NULL     = 4'd10;
    localparam logic [3:0] K_ERROR    = 4'd11;
    localparam logic [3:0] K_END      = 4'd12;

    // Keyword candidate bits: true, false, null.
    localparam logic [2:0] KW_ALL = 3'b111;
    localparam int KW_TRUE_BIT  = 0;
    localparam int KW_FALSE_BIT = 1;
    localparam int KW_NULL_BIT  = 2;

    typedef struct packed {
        logic       is_payload;
        logic [3:0] kind;
        logic [7:0] data;
    } token_t;

    typedef struct packed {
        logic [1:0] n;
        token_t     r0;
        token_t     r1;
    } emit_t;

    typedef struct packed {
        logic              is_payload;
        logic [3:0]        kind;
        logic [7:0]        data;
        logic [LINE_W-1:0] line;
        logic              last;
    } result_t;

    function automatic emit_t emit_push(emit_t e, logic p, logic [3:0] k, logic [7:0] d);
        emit_t r;
        r = e;
        if (e.n == 2'd0)
        begin
            r.r0 = '{is_payload: p, kind: k, data: d};
            r.n  = 2'd1;
        end
        else if (e.n == 2'd1)
        begin
            r.r1 = '{is_payload: p, kind: k, data: d};
            r.n  = 2'd2;
        end
        return r;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_hex(logic [7:0] c);
        return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
    endfunction

    function automatic logic is_word(logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == "_");
    endfunction

    function automatic logic [2:0] kw_len(logic [1:0] k);
        logic [2:0] r;
        case (k)
            2'd1:    r = 3'd5;
            default: r = 3'd4;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] kw_char(logic [1:0] k, logic [2:0] pos);
        logic [7:0] r;
        r = 8'h00;
        case ({k, pos})
            {2'd0, 3'd0}: r = "t";
            {2'd0, 3'd1}: r = "r";
            {2'd0, 3'd2}: r = "u";
            {2'd0, 3'd3}: r = "e";
            {2'd1, 3'd0}: r = "f";
            {2'd1, 3'd1}: r = "a";
            {2'd1, 3'd2}: r = "l";
            {2'd1, 3'd3}: r = "s";
            {2'd1, 3'd4}: r = "e";
            {2'd2, 3'd0}: r = "n";
            {2'd2, 3'd1}: r = "u";
            {2'd2, 3'd2}: r = "l";
            {2'd2, 3'd3}: r = "l";
            default:      r = 8'h00;
        endcase
        return r;
    endfunction

    // Drops every keyword that the byte at position pos rules out.
    function automatic logic [2:0] kw_update(logic [2:0] m, logic [2:0] pos, logic pos_ok,
                                             logic [7:0] c);
        logic [2:0] r;
        r = m;
        for (int k = 0; k < 3; k++)
        begin
            if (!pos_ok || (pos >= kw_len(2'(k))) || (kw_char(2'(k), pos) != c))
            begin
                r[k] = 1'b0;
            end
        end
        return r;
    endfunction

endpackage

@@ rtl/core/ont_lexer.sv @@
module ont_lexer #(
    parameter int LCNT_W = 10
) (
    input  logic [ont_pkg::MODE_W-1:0] mode,
    input  logic [LCNT_W-1:0]          lcnt,
    input  logic [2:0]                 kw,
    input  logic [LCNT_W-1:0]          string_limit,
    input  logic [LCNT_W-1:0]          word_limit,
    input  logic [7:0]                 data_byte,
    input  logic                       end_of_input,
    output logic [ont_pkg::MODE_W-1:0] mode_next,
    output logic [LCNT_W-1:0]          lcnt_next,
    output logic [2:0]                 kw_next,
    output logic                       line_inc,
    output ont_pkg::emit_t             emits
);
    import ont_pkg::*;

    logic [7:0]        c;
    logic              redo;
    logic              store;
    logic              num;
    logic              num_ok;
    logic              pos_ok;
    logic [LCNT_W-1:0] cnt_inc;
    logic [3:0]        ident_kind;
    emit_t             e;

    assign cnt_inc = lcnt + LCNT_W'(1);
    assign pos_ok  = lcnt < LCNT_W'(5);

    always_comb
    begin
        if ((lcnt == LCNT_W'(4)) && kw[KW_TRUE_BIT])
        begin
            ident_kind = K_TRUE;
        end
        else if ((lcnt == LCNT_W'(5)) && kw[KW_FALSE_BIT])
        begin
            ident_kind = K_FALSE;
        end
        else if ((lcnt == LCNT_W'(4)) && kw[KW_NULL_BIT])
        begin
            ident_kind = K_NULL;
        end
        else
        begin
            ident_kind = K_STRING;
        end
    end

    always_comb
    begin
        c         = data_byte;
        redo      = 1'b0;
        store     = 1'b0;
        num       = 1'b0;
        num_ok    = 1'b0;
        e         = '0;
        mode_next = mode;
        lcnt_next = lcnt;
        kw_next   = kw;
        line_inc  = 1'b0;

        if (end_of_input)
        begin
            case (mode)
                M_STR, M_STR_ESC:    e = emit_push(e, 1'b0, K_STRING, 8'h00);
                M_ZERO, M_DEC, M_HEX: e = emit_push(e, 1'b0, K_NUMBER, 8'h00);
                M_IDENT:             e = emit_push(e, 1'b0, ident_kind, 8'h00);
                M_SLASH:             e = emit_push(e, 1'b0, K_ERROR, 8'h00);
                default:             e = e;
            endcase
            e         = emit_push(e, 1'b0, K_END, 8'h00);
            mode_next = M_IDLE;
            lcnt_next = '0;
            kw_next   = KW_ALL;
        end
        else
        begin
            case (mode)
                M_SLASH:
                begin
                    if (c == "/")
                    begin
                        mode_next = M_COMMENT;
                    end
                    else
                    begin
                        e    = emit_push(e, 1'b0, K_ERROR, 8'h00);
                        redo = 1'b1;
                    end
                end
                M_COMMENT:
                begin
                    if (c == 8'h0A)
                    begin
                        line_inc  = 1'b1;
                        mode_next = M_IDLE;
                        lcnt_next = '0;
                        kw_next   = KW_ALL;
                    end
                end
                M_STR:
                begin
                    if (c == 8'h22)
                    begin
                        e         = emit_push(e, 1'b0, K_STRING, 8'h00);
                        mode_next = M_IDLE;
                        lcnt_next = '0;
                        kw_next   = KW_ALL;
                    end
                    else if (c == 8'h5C)
                    begin
                        mode_next = M_STR_ESC;
                    end
                    else
                    begin
                        store = 1'b1;
                    end
                end
                M_STR_ESC:
                begin
                    if (c == "n")
                    begin
                        c = 8'h0A;
                    end
                    else if (c == "t")
                    begin
                        c = 8'h09;
                    end
                    else if (c == "r")
                    begin
                        c = 8'h0D;
                    end
                    store = 1'b1;
                end
                M_STR_DROP:
                begin
                    mode_next = M_IDLE;
                    lcnt_next = '0;
                    kw_next   = KW_ALL;
                end
                M_ZERO:
                begin
                    if ((c == "x") || (c == "X"))
                    begin
                        // The hex prefix is always passed on, even at the length limit.
                        e = emit_push(e, 1'b1, K_NUMBER, c);
                        if (lcnt < word_limit)
                        begin
                            lcnt_next = cnt_inc;
                        end
                        mode_next = M_HEX;
                    end
                    else
                    begin
                        mode_next = M_DEC;
                        num       = 1'b1;
                        num_ok    = is_digit(c) || (c == ".");
                    end
                end
                M_DEC:
                begin
                    num    = 1'b1;
                    num_ok = is_digit(c) || (c == ".");
                end
                M_HEX:
                begin
                    num    = 1'b1;
                    num_ok = is_hex(c);
                end
                M_IDENT:
                begin
                    if (is_word(c) && (lcnt < word_limit))
                    begin
                        e         = emit_push(e, 1'b1, K_STRING, c);
                        kw_next   = kw_update(kw, lcnt[2:0], pos_ok, c);
                        lcnt_next = cnt_inc;
                    end
                    else
                    begin
                        e    = emit_push(e, 1'b0, ident_kind, 8'h00);
                        redo = 1'b1;
                    end
                end
                default:
                begin
                    redo = 1'b1;
                end
            endcase

            if (store)
            begin
                e         = emit_push(e, 1'b1, K_STRING, c);
                lcnt_next = cnt_inc;
                if (cnt_inc >= string_limit)
                begin
                    e         = emit_push(e, 1'b0, K_STRING, 8'h00);
                    mode_next = M_STR_DROP;
                end
                else
                begin
                    mode_next = M_STR;
                end
            end

            // Digits past the length limit are swallowed silently.
            if (num)
            begin
                if (num_ok)
                begin
                    if (lcnt < word_limit)
                    begin
                        e         = emit_push(e, 1'b1, K_NUMBER, c);
                        lcnt_next = cnt_inc;
                    end
                end
                else
                begin
                    e    = emit_push(e, 1'b0, K_NUMBER, 8'h00);
                    redo = 1'b1;
                end
            end

            // The byte that closed a token is looked at again as a fresh start.
            if (redo)
            begin
                mode_next = M_IDLE;
                lcnt_next = '0;
                kw_next   = KW_ALL;
                case (c)
                    8'h0A:                      line_inc = 1'b1;
                    8'h20, 8'h09, 8'h0B, 8'h0C,
                    8'h0D:                      line_inc = 1'b0;
                    "/":                        mode_next = M_SLASH;
                    "{":                        e = emit_push(e, 1'b0, K_LBRACE, 8'h00);
                    "}":                        e = emit_push(e, 1'b0, K_RBRACE, 8'h00);
                    "[":                        e = emit_push(e, 1'b0, K_LBRACKET, 8'h00);
                    "]":                        e = emit_push(e, 1'b0, K_RBRACKET, 8'h00);
                    ":":                        e = emit_push(e, 1'b0, K_COLON, 8'h00);
                    ",":                        e = emit_push(e, 1'b0, K_COMMA, 8'h00);
                    8'h22:                      mode_next = M_STR;
                    default:
                    begin
                        if (c == "0")
                        begin
                            e         = emit_push(e, 1'b1, K_NUMBER, c);
                            lcnt_next = LCNT_W'(1);
                            mode_next = M_ZERO;
                        end
                        else if (is_digit(c) || (c == "-"))
                        begin
                            e         = emit_push(e, 1'b1, K_NUMBER, c);
                            lcnt_next = LCNT_W'(1);
                            mode_next = M_DEC;
                        end
                        else if (is_alpha(c) || (c == "_"))
                        begin
                            e         = emit_push(e, 1'b1, K_STRING, c);
                            kw_next   = kw_update(KW_ALL, 3'd0, 1'b1, c);
                            lcnt_next = LCNT_W'(1);
                            mode_next = M_IDENT;
                        end
                        else
                        begin
                            e = emit_push(e, 1'b0, K_ERROR, 8'h00);
                        end
                    end
                endcase
            end
        end

        emits = e;
    end

endmodule

@@ rtl/core/ont_outq.sv @@
module ont_outq (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       push_count,
    input  ont_pkg::result_t push0,
    input  ont_pkg::result_t push1,
    input  logic             pop,
    output logic             has_room,
    output logic             head_valid,
    output ont_pkg::result_t head
);
    import ont_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;

    result_t           slot [DEPTH];
    logic [PTR_W-1:0]  wr_reg;
    logic [PTR_W-1:0]  wr_next;
    logic [PTR_W-1:0]  rd_reg;
    logic [PTR_W-1:0]  rd_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign wr_next    = wr_reg + PTR_W'(push_count);
    assign rd_next    = rd_reg + PTR_W'(pop);
    assign count_next = count_reg + CNT_W'(push_count) - CNT_W'(pop);

    // Room for two beats is kept so that any byte can be taken in.
    assign has_room   = count_reg <= CNT_W'(DEPTH - 2);
    assign head_valid = count_reg != '0;
    assign head       = slot[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            slot[wr_reg] <= push0;
        end
        if (push_count == 2'd2)
        begin
            slot[wr_reg + PTR_W'(1)] <= push1;
        end
    end

endmodule

@@ rtl/core/object_notation_tokenizer.sv @@
// Byte-stream tokenizer for a JSON-like notation. One byte is taken per clock; it updates a
// small mode machine in the same cycle and its results (a payload byte, a token end, or both
// when a byte closes one token and opens the next) go into a four-beat output queue. A byte
// is accepted in every cycle while the queue has room for two beats, so the input runs at one
// byte per cycle as long as the output side takes one beat per cycle; a byte that gives two
// beats pushes both into the queue at once, and the output port's one beat per cycle is the
// limit on sustained throughput. Limits written through the configuration port take effect
// from the next byte and should be written while the block is idle.
module object_notation_tokenizer #(
    parameter int STRING_BUFFER = ont_pkg::STRING_BUFFER_DEF,
    parameter int WORD_BUFFER   = ont_pkg::WORD_BUFFER_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [ont_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ont_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      data_byte,
    input  logic                            end_of_input,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            is_payload,
    output logic [3:0]                      token_kind,
    output logic [7:0]                      out_byte,
    output logic [ont_pkg::LINE_W-1:0]      line_number,
    output logic                            last_result
);
    import ont_pkg::*;

    localparam int BIG_BUFFER = (STRING_BUFFER > WORD_BUFFER) ? STRING_BUFFER : WORD_BUFFER;
    // At least three bits so that the keyword lengths can be compared.
    localparam int LCNT_W     = ($clog2(BIG_BUFFER) > 3) ? $clog2(BIG_BUFFER) : 3;
    localparam int SMAX       = STRING_BUFFER - 1;
    localparam int WMAX       = WORD_BUFFER - 1;
    localparam int SLIM_RST   = (STRING_LIMIT_RESET > SMAX) ? SMAX : STRING_LIMIT_RESET;
    localparam int WLIM_RST   = (WORD_LIMIT_RESET > WMAX) ? WMAX : WORD_LIMIT_RESET;

    function automatic logic [LCNT_W-1:0] eff_limit(logic [CFG_DATA_W-1:0] v, int lim);
        logic [LCNT_W-1:0] r;
        if (v == '0)
        begin
            r = LCNT_W'(1);
        end
        else if (int'(v) > lim)
        begin
            r = LCNT_W'(lim);
        end
        else
        begin
            r = LCNT_W'(v);
        end
        return r;
    endfunction

    logic [LCNT_W-1:0] slim_reg;
    logic [LCNT_W-1:0] wlim_reg;
    logic [MODE_W-1:0] mode_reg;
    logic [MODE_W-1:0] mode_next;
    logic [LCNT_W-1:0] lcnt_reg;
    logic [LCNT_W-1:0] lcnt_next;
    logic [2:0]        kw_reg;
    logic [2:0]        kw_next;
    logic [LINE_W-1:0] line_reg;
    logic [LINE_W-1:0] line_next;
    logic              line_inc;
    logic              accept;
    logic              has_room;
    logic              pop;
    logic [1:0]        push_count;
    emit_t             step;
    result_t           push0;
    result_t           push1;
    result_t           head;

    assign in_stall = !has_room;
    assign accept   = in_valid && has_room;
    assign pop      = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slim_reg <= LCNT_W'(SLIM_RST);
            wlim_reg <= LCNT_W'(WLIM_RST);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_STRING_LIMIT: slim_reg <= eff_limit(cfg_data, SMAX);
                CFG_WORD_LIMIT:
                begin
                    wlim_reg <= eff_limit(CFG_DATA_W'(cfg_data[WORD_LIMIT_W-1:0]), WMAX);
                end
                default:          slim_reg <= slim_reg;
            endcase
        end
    end

    ont_lexer #(
        .LCNT_W (LCNT_W)
    ) u_lexer (
        .mode         (mode_reg),
        .lcnt         (lcnt_reg),
        .kw           (kw_reg),
        .string_limit (slim_reg),
        .word_limit   (wlim_reg),
        .data_byte    (data_byte),
        .end_of_input (end_of_input),
        .mode_next    (mode_next),
        .lcnt_next    (lcnt_next),
        .kw_next      (kw_next),
        .line_inc     (line_inc),
        .emits        (step)
    );

    // The line counter sticks at its maximum.
    assign line_next = (line_inc && (line_reg != '1)) ? line_reg + LINE_W'(1) : line_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            lcnt_reg <= '0;
            kw_reg   <= KW_ALL;
            line_reg <= LINE_W'(1);
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            lcnt_reg <= lcnt_next;
            kw_reg   <= kw_next;
            line_reg <= line_next;
        end
    end

    // Every beat of one byte carries the line count from before that byte.
    assign push_count = accept ? step.n : 2'd0;
    assign push0 = '{is_payload: step.r0.is_payload, kind: step.r0.kind, data: step.r0.data,
                     line: line_reg, last: (step.n == 2'd1)};
    assign push1 = '{is_payload: step.r1.is_payload, kind: step.r1.kind, data: step.r1.data,
                     line: line_reg, last: 1'b1};

    ont_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push0      (push0),
        .push1      (push1),
        .pop        (pop),
        .has_room   (has_room),
        .head_valid (out_valid),
        .head       (head)
    );

    assign is_payload  = head.is_payload;
    assign token_kind  = head.kind;
    assign out_byte    = head.data;
    assign line_number = head.line;
    assign last_result = head.last;

    a_eoi_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_of_input |=> (mode_reg == M_IDLE) && (lcnt_reg == '0))
        else $error("end of input did not return the lexer to idle");

    a_eoi_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_of_input |-> (step.n != 2'd0))
        else $error("end of input produced no end beat");

    a_line_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (line_reg >= $past(line_reg)))
        else $error("line count went backwards");

    a_string_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == M_STR) || (mode_reg == M_STR_ESC) |-> (lcnt_reg < slim_reg))
        else $error("open string holds as many bytes as its limit");

endmodule

@@ dv/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ont_pkg::*;

    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_VT  = 8'h0B;
    localparam logic [7:0] CH_FF  = 8'h0C;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;

    localparam int CYCLE_LIMIT      = 600000;
    localparam int DRAIN_LIMIT      = 5000;
    localparam int SETTLE_CYCLES    = 16;
    localparam int SINK_HOLD_CYCLES = 300;
    localparam int MAX_REPORTS      = 40;

    localparam string STRUCT_SET     = "{}[]:,";
    localparam string WORD_START_SET = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    localparam string WORD_SET       = "abcdeflnrstuxyzABCDEFLNRSTUXZ0123456789_";
    localparam string DEC_SET        = "0123456789.";
    localparam string HEX_SET        = "0123456789abcdefABCDEF";
    localparam string ESC_SET        = "ntr";

    logic                   clk;
    logic                   rst_n        = 1'b0;
    logic                   cfg_write    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;
    logic                   in_valid     = 1'b0;
    logic                   in_stall;
    logic [7:0]             data_byte    = 8'h00;
    logic                   end_of_input = 1'b0;
    logic                   out_valid;
    logic                   out_stall    = 1'b0;
    logic                   is_payload;
    logic [3:0]             token_kind;
    logic [7:0]             out_byte;
    logic [LINE_W-1:0]      line_number;
    logic                   last_result;

    int src_gap_pct    = 0;
    int sink_stall_pct = 0;
    bit sink_hold_req  = 1'b0;
    int beats_sent     = 0;
    int str_cap_now    = STRING_LIMIT_RESET;
    int word_cap_now   = WORD_LIMIT_RESET;
    int cycle_count    = 0;

    object_notation_tokenizer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .is_payload   (is_payload),
        .token_kind   (token_kind),
        .out_byte     (out_byte),
        .line_number  (line_number),
        .last_result  (last_result)
    );

    // Tracks the lexer state byte by byte and holds the token beats still owed by the block.
    class token_tracker;
        logic [MODE_W-1:0] mode;
        logic [9:0]        run_len;
        logic [LINE_W-1:0] line;
        logic [2:0]        kw_live;
        logic [9:0]        string_cap;
        logic [5:0]        word_cap;
        result_t           pending_tokens[$];
        result_t           step_tokens[$];
        int unsigned       fail_count;
        string             keywords[3];

        function new();
            keywords[0] = "true";
            keywords[1] = "false";
            keywords[2] = "null";
            fail_count  = 0;
            line        = 1;
            string_cap  = 10'(STRING_LIMIT_RESET);
            word_cap    = 6'(WORD_LIMIT_RESET);
            restart();
        endfunction

        function void restart();
            mode    = M_IDLE;
            run_len = '0;
            kw_live = KW_ALL;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            if (idx == CFG_STRING_LIMIT)
            begin
                string_cap = value[9:0];
            end
            else
            begin
                word_cap = value[5:0];
            end
        endfunction

        function int unsigned limit_of(int unsigned v, int unsigned depth);
            if (v == 0)
            begin
                v = 1;
            end
            if (v > depth - 1)
            begin
                v = depth - 1;
            end
            return v;
        endfunction

        function bit digit_char(logic [7:0] c);
            return (c >= "0") && (c <= "9");
        endfunction

        function bit alpha_char(logic [7:0] c);
            return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
        endfunction

        function bit hex_char(logic [7:0] c);
            return digit_char(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
        endfunction

        function bit word_char(logic [7:0] c);
            return alpha_char(c) || digit_char(c) || (c == "_");
        endfunction

        // At most two beats leave the block for one input byte.
        function void push(logic p, logic [3:0] k, logic [7:0] d);
            result_t r;
            if (step_tokens.size() < 2)
            begin
                r.is_payload = p;
                r.kind       = k;
                r.data       = d;
                r.line       = line;
                r.last       = 1'b0;
                step_tokens.push_back(r);
            end
        endfunction

        function void bump_line();
            if (line != '1)
            begin
                line = line + 1'b1;
            end
        endfunction

        function void kw_step(int unsigned pos, logic [7:0] c);
            for (int k = 0; k < 3; k++)
            begin
                if (kw_live[k] && ((pos >= keywords[k].len()) || (keywords[k][pos] != c)))
                begin
                    kw_live[k] = 1'b0;
                end
            end
        endfunction

        function logic [3:0] ident_end_kind();
            if (run_len == 4 && kw_live[KW_TRUE_BIT])
            begin
                return K_TRUE;
            end
            if (run_len == 5 && kw_live[KW_FALSE_BIT])
            begin
                return K_FALSE;
            end
            if (run_len == 4 && kw_live[KW_NULL_BIT])
            begin
                return K_NULL;
            end
            return K_STRING;
        endfunction

        function void open_token(logic [7:0] c);
            restart();
            case (c)
                CH_LF:                             bump_line();
                CH_SP, CH_TAB, CH_VT, CH_FF, CH_CR: ;
                "/":                               mode = M_SLASH;
                "{":                               push(1'b0, K_LBRACE, 8'h00);
                "}":                               push(1'b0, K_RBRACE, 8'h00);
                "[":                               push(1'b0, K_LBRACKET, 8'h00);
                "]":                               push(1'b0, K_RBRACKET, 8'h00);
                ":":                               push(1'b0, K_COLON, 8'h00);
                ",":                               push(1'b0, K_COMMA, 8'h00);
                "\"":                              mode = M_STR;
                default:
                begin
                    if (c == "0")
                    begin
                        push(1'b1, K_NUMBER, c);
                        run_len = 10'd1;
                        mode    = M_ZERO;
                    end
                    else if (digit_char(c) || c == "-")
                    begin
                        push(1'b1, K_NUMBER, c);
                        run_len = 10'd1;
                        mode    = M_DEC;
                    end
                    else if (alpha_char(c) || c == "_")
                    begin
                        push(1'b1, K_STRING, c);
                        kw_step(0, c);
                        run_len = 10'd1;
                        mode    = M_IDENT;
                    end
                    else
                    begin
                        push(1'b0, K_ERROR, 8'h00);
                    end
                end
            endcase
        endfunction

        function void store_string_byte(logic [7:0] b);
            push(1'b1, K_STRING, b);
            run_len = run_len + 1'b1;
            if (run_len >= limit_of(string_cap, STRING_BUFFER_DEF))
            begin
                push(1'b0, K_STRING, 8'h00);
                mode = M_STR_DROP;
            end
            else
            begin
                mode = M_STR;
            end
        endfunction

        function void number_byte(logic [7:0] c, bit ok);
            if (ok)
            begin
                if (run_len < limit_of(word_cap, WORD_BUFFER_DEF))
                begin
                    push(1'b1, K_NUMBER, c);
                    run_len = run_len + 1'b1;
                end
            end
            else
            begin
                push(1'b0, K_NUMBER, 8'h00);
                open_token(c);
            end
        endfunction

        function void take_byte(logic [7:0] c, logic eoi);
            logic [7:0] b;
            result_t    r;
            step_tokens.delete();
            if (eoi)
            begin
                case (mode)
                    M_STR, M_STR_ESC:    push(1'b0, K_STRING, 8'h00);
                    M_ZERO, M_DEC, M_HEX: push(1'b0, K_NUMBER, 8'h00);
                    M_IDENT:             push(1'b0, ident_end_kind(), 8'h00);
                    M_SLASH:             push(1'b0, K_ERROR, 8'h00);
                    default:             ;
                endcase
                push(1'b0, K_END, 8'h00);
                restart();
            end
            else
            begin
                case (mode)
                    M_SLASH:
                    begin
                        if (c == "/")
                        begin
                            mode = M_COMMENT;
                        end
                        else
                        begin
                            push(1'b0, K_ERROR, 8'h00);
                            open_token(c);
                        end
                    end
                    M_COMMENT:
                    begin
                        if (c == CH_LF)
                        begin
                            bump_line();
                            restart();
                        end
                    end
                    M_STR:
                    begin
                        if (c == "\"")
                        begin
                            push(1'b0, K_STRING, 8'h00);
                            restart();
                        end
                        else if (c == "\\")
                        begin
                            mode = M_STR_ESC;
                        end
                        else
                        begin
                            store_string_byte(c);
                        end
                    end
                    M_STR_ESC:
                    begin
                        b = c;
                        if (c == "n")
                        begin
                            b = CH_LF;
                        end
                        else if (c == "t")
                        begin
                            b = CH_TAB;
                        end
                        else if (c == "r")
                        begin
                            b = CH_CR;
                        end
                        store_string_byte(b);
                    end
                    M_STR_DROP:
                    begin
                        restart();
                    end
                    M_ZERO:
                    begin
                        // The x of a hex prefix is always passed on, even at a word limit of one.
                        if (c == "x" || c == "X")
                        begin
                            push(1'b1, K_NUMBER, c);
                            if (run_len < limit_of(word_cap, WORD_BUFFER_DEF))
                            begin
                                run_len = run_len + 1'b1;
                            end
                            mode = M_HEX;
                        end
                        else
                        begin
                            mode = M_DEC;
                            number_byte(c, digit_char(c) || c == ".");
                        end
                    end
                    M_DEC:
                    begin
                        number_byte(c, digit_char(c) || c == ".");
                    end
                    M_HEX:
                    begin
                        number_byte(c, hex_char(c));
                    end
                    M_IDENT:
                    begin
                        if (word_char(c) && run_len < limit_of(word_cap, WORD_BUFFER_DEF))
                        begin
                            push(1'b1, K_STRING, c);
                            kw_step(run_len, c);
                            run_len = run_len + 1'b1;
                        end
                        else
                        begin
                            push(1'b0, ident_end_kind(), 8'h00);
                            open_token(c);
                        end
                    end
                    default:
                    begin
                        open_token(c);
                    end
                endcase
            end
            foreach (step_tokens[i])
            begin
                r      = step_tokens[i];
                r.last = (i == step_tokens.size() - 1);
                pending_tokens.push_back(r);
            end
        endfunction

        function void field_check(string name, logic [LINE_W-1:0] want, logic [LINE_W-1:0] got);
            if (want !== got)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                begin
                    $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
                end
            end
        endfunction

        function void match_token(result_t got);
            result_t want;
            if (pending_tokens.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                begin
                    $display("%0t: unexpected beat: expected none, actual %0b/%0d/%0h/%0d/%0b",
                             $time, got.is_payload, got.kind, got.data, got.line, got.last);
                end
                return;
            end
            want = pending_tokens.pop_front();
            field_check("is_payload", want.is_payload, got.is_payload);
            field_check("token_kind", want.kind, got.kind);
            field_check("out_byte", want.data, got.data);
            field_check("line_number", want.line, got.line);
            field_check("last_result", want.last, got.last);
        endfunction
    endclass

    token_tracker tracker;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin : cycle_guard
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    // Output beats are sampled at the falling edge, where valid and stall are settled.
    always @(negedge clk)
    begin
        result_t seen;
        if (rst_n && out_valid && !out_stall)
        begin
            seen.is_payload = is_payload;
            seen.kind       = token_kind;
            seen.data       = out_byte;
            seen.line       = line_number;
            seen.last       = last_result;
            tracker.match_token(seen);
        end
    end

    initial
    begin : sink_pacing
        int burst;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (sink_hold_req)
            begin
                sink_hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (SINK_HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct)
            begin
                burst = $urandom_range(1, 7);
                out_stall <= 1'b1;
                repeat (burst) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    function automatic logic [7:0] pick_from(string set);
        return set[$urandom_range(0, set.len() - 1)];
    endfunction

    function automatic logic [7:0] pick_space();
        case ($urandom_range(0, 6))
            0:       return CH_TAB;
            1, 2:    return CH_LF;
            3:       return CH_CR;
            4:       return CH_VT;
            5:       return CH_FF;
            default: return CH_SP;
        endcase
    endfunction

    function automatic int word_len_pick();
        if ($urandom_range(0, 7) == 0)
        begin
            return $urandom_range(1, word_cap_now + 3);
        end
        return $urandom_range(1, 6);
    endfunction

    function automatic int string_len_pick();
        if ($urandom_range(0, 9) == 0 && str_cap_now <= 64)
        begin
            return str_cap_now - 1 + $urandom_range(0, 2);
        end
        return $urandom_range(0, 12);
    endfunction

    // Offers one byte, holding it until the block takes the beat.
    task automatic send_byte(input logic [7:0] b, input logic eoi);
        bit taken;
        if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        data_byte    <= b;
        end_of_input <= eoi;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        tracker.take_byte(b, eoi);
        beats_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i], 1'b0);
        end
    endtask

    task automatic send_string_token(input int len);
        logic [7:0] b;
        send_byte("\"", 1'b0);
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    send_byte("\\", 1'b0);
                    if ($urandom_range(0, 1))
                    begin
                        b = pick_from(ESC_SET);
                    end
                    else
                    begin
                        b = 8'($urandom_range(0, 255));
                    end
                    send_byte(b, 1'b0);
                end
                1, 2, 3:
                begin
                    b = 8'($urandom_range(0, 255));
                    if (b == "\"" || b == "\\")
                    begin
                        b = "~";
                    end
                    send_byte(b, 1'b0);
                end
                default:
                begin
                    send_byte(pick_from(WORD_SET), 1'b0);
                end
            endcase
        end
        // An unterminated string now and then runs into the following tokens.
        if ($urandom_range(0, 7) != 0)
        begin
            send_byte("\"", 1'b0);
        end
    endtask

    task automatic send_number_token();
        int len;
        len = word_len_pick();
        case ($urandom_range(0, 3))
            0:
            begin
                if ($urandom_range(0, 1))
                begin
                    send_byte("-", 1'b0);
                end
                repeat (len) send_byte(pick_from(DEC_SET), 1'b0);
            end
            1:
            begin
                send_byte("0", 1'b0);
                repeat (len) send_byte(pick_from(DEC_SET), 1'b0);
            end
            default:
            begin
                send_byte("0", 1'b0);
                send_byte($urandom_range(0, 1) ? "x" : "X", 1'b0);
                repeat (len) send_byte(pick_from(HEX_SET), 1'b0);
            end
        endcase
    endtask

    task automatic send_word_token();
        int len;
        len = word_len_pick();
        case ($urandom_range(0, 5))
            0: send_text("true");
            1: send_text("false");
            2: send_text("null");
            3:
            begin
                case ($urandom_range(0, 5))
                    0:       send_text("tru");
                    1:       send_text("truex");
                    2:       send_text("falsey");
                    3:       send_text("nul");
                    4:       send_text("nulls");
                    default: send_text("Null");
                endcase
            end
            default:
            begin
                send_byte(pick_from(WORD_START_SET), 1'b0);
                repeat (len - 1) send_byte(pick_from(WORD_SET), 1'b0);
            end
        endcase
    endtask

    task automatic random_piece();
        int         pick;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 14)
        begin
            send_byte(pick_from(STRUCT_SET), 1'b0);
        end
        else if (pick < 26)
        begin
            send_byte(pick_space(), 1'b0);
        end
        else if (pick < 41)
        begin
            send_string_token(string_len_pick());
        end
        else if (pick < 56)
        begin
            send_number_token();
        end
        else if (pick < 74)
        begin
            send_word_token();
        end
        else if (pick < 79)
        begin
            send_text("//");
            repeat ($urandom_range(0, 10))
            begin
                b = 8'($urandom_range(0, 255));
                if (b == CH_LF)
                begin
                    b = "#";
                end
                send_byte(b, 1'b0);
            end
            send_byte(CH_LF, 1'b0);
        end
        else if (pick < 83)
        begin
            send_byte("/", 1'b0);
        end
        else if (pick < 95)
        begin
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
        else
        begin
            send_byte(8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    // Lowers valid and lets every owed beat come back, then allows for work still in flight.
    task automatic wait_drained();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (tracker.pending_tokens.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (tracker.pending_tokens.size() != 0)
        begin
            tracker.fail_count += tracker.pending_tokens.size();
            $display("%0t: beats never delivered: expected %0d more, actual 0",
                     $time, tracker.pending_tokens.size());
            tracker.pending_tokens.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        tracker.set_reg(idx, value);
        @(posedge clk);
    endtask

    task automatic run_phase(input int str_lim, input int word_lim, input int gap,
                             input int stall, input int items, input bit long_string,
                             input bit hold);
        int first;
        write_reg(CFG_STRING_LIMIT, CFG_DATA_W'(str_lim));
        write_reg(CFG_WORD_LIMIT, CFG_DATA_W'(word_lim));
        str_cap_now    = (str_lim == 0) ? 1 : str_lim;
        word_cap_now   = (word_lim == 0) ? 1 : word_lim;
        src_gap_pct    = gap;
        sink_stall_pct = stall;
        if (hold)
        begin
            sink_hold_req = 1'b1;
        end
        first = beats_sent;
        if (long_string)
        begin
            send_string_token(str_cap_now + 1);
        end
        while (beats_sent - first < items)
        begin
            random_piece();
        end
        // Close any open token so that the next limits start from an idle lexer.
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        wait_drained();
    endtask

    initial
    begin : stimulus
        tracker = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Structural tokens, an unknown escape, a hex number ended by a sign, a keyword,
        // a lone slash before a stray byte, and the extreme byte values.
        send_text("{}[]:,\"\\n\\q\"0xF- null/!");
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        wait_drained();

        run_phase(1, 1, 20, 20, 80, 1'b0, 1'b0);
        run_phase(5, 3, 0, 0, 60, 1'b0, 1'b0);
        run_phase(0, 0, 30, 30, 50, 1'b0, 1'b0);
        run_phase(1023, 63, 10, 10, 1150, 1'b1, 1'b0);
        run_phase($urandom_range(2, 40), $urandom_range(2, 62), 25, 25, 90, 1'b0, 1'b1);
        run_phase(8, 63, 15, 40, 70, 1'b0, 1'b0);
        run_phase($urandom_range(1, 1023), $urandom_range(1, 63), 0, 0, 70, 1'b0, 1'b0);

        if (tracker.fail_count == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
